/* src/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks sampled on clk, off while rst_n is low.
`define ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");

`define ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

/* src/bxds_pkg.sv */
package bxds_pkg;

  localparam int PIX_W          = 8;
  localparam int QUO_W          = 8;
  localparam int CFG_W          = 13;
  localparam int CFG_IDX_W      = 2;
  localparam int STRIDE_CFG_W   = 5;
  localparam int MAX_HEIGHT     = 4096;
  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_MAX_STRIDE = 16;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE_HEIGHT = 2'd3;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_DONE
  } div_state_t;

endpackage

/* src/bxds_if.sv */
interface bxds_in_if;
  logic                       valid;
  logic                       ready;
  logic [bxds_pkg::PIX_W-1:0] red;
  logic [bxds_pkg::PIX_W-1:0] green;
  logic [bxds_pkg::PIX_W-1:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

interface bxds_out_if;
  logic                       valid;
  logic                       ready;
  logic [bxds_pkg::PIX_W-1:0] red_average;
  logic [bxds_pkg::PIX_W-1:0] green_average;
  logic [bxds_pkg::PIX_W-1:0] blue_average;
  logic                       frame_end;

  modport source (output valid, red_average, green_average, blue_average, frame_end,
                  input ready);
  modport sink   (input valid, red_average, green_average, blue_average, frame_end,
                  output ready);
endinterface

/* src/box_average_downscaler.sv */
// Channel   Direction  Content
// --------  ---------  ---------------------------------------------------
// in_pix    in         red, green, blue source pixel, raster order
// out_pix   out        red/green/blue_average, frame_end per full block
// cfg_*     in         write enable, register index, 13-bit data
//
// A pixel that closes no block does not hold the input: it reads its column sum from
// the band memory when taken and writes it back the next cycle (forwarded
// when the next pixel hits the same column). A pixel that closes a block
// holds the input through write back, 8 steps of the shared restoring
// divider (one quotient bit a cycle for all three channels) and output load.
// Reset is synchronous; the band memory is not cleared. A stalled output
// keeps the finished item in the output register while pixels are taken.

`include "assert_macros.svh"

module box_average_downscaler #(
  parameter int MAX_WIDTH  = bxds_pkg::DEF_MAX_WIDTH,
  parameter int MAX_STRIDE = bxds_pkg::DEF_MAX_STRIDE
) (
  input  logic                           clk,
  input  logic                           rst_n,
  bxds_in_if.sink                        in_pix,
  bxds_out_if.source                     out_pix,
  input  logic                           cfg_we,
  input  logic [bxds_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bxds_pkg::CFG_W-1:0]     cfg_data
);

  localparam int PIX_W = bxds_pkg::PIX_W;
  localparam int QUO_W = bxds_pkg::QUO_W;
  localparam int MAX_H = bxds_pkg::MAX_HEIGHT;
  localparam int WMAX  = (MAX_WIDTH < MAX_H) ? MAX_WIDTH : MAX_H;
  localparam int AW    = $clog2(MAX_WIDTH);
  localparam int WD_W  = $clog2(WMAX + 1);
  localparam int SC_W  = $clog2(WMAX);
  localparam int HD_W  = $clog2(MAX_H + 1);
  localparam int SR_W  = $clog2(MAX_H);
  localparam int SW_W  = $clog2(MAX_STRIDE + 1);
  localparam int PH_W  = $clog2(MAX_STRIDE);
  localparam int CNT_W = $clog2(MAX_STRIDE * MAX_STRIDE + 1);
  localparam int SUM_W = $clog2(MAX_STRIDE * MAX_STRIDE * (2 ** PIX_W - 1) + 1);
  localparam int DW    = CNT_W + QUO_W;
  localparam int KW    = $clog2(QUO_W);
  localparam int XW    = $clog2(MAX_H + 2 * MAX_STRIDE + 1) + 1;

  // configuration, stored clamped
  logic [WD_W-1:0] w_r;
  logic [HD_W-1:0] h_r;
  logic [SW_W-1:0] sw_r, sh_r;
  logic [WD_W-1:0] w_cl;
  logic [HD_W-1:0] h_cl;
  logic [SW_W-1:0] s_cl;
  logic [bxds_pkg::STRIDE_CFG_W-1:0] cfg_s5;

  // frame position
  logic [SC_W-1:0] src_col_r, src_col_nxt;
  logic [SR_W-1:0] src_row_r, src_row_nxt;
  logic [PH_W-1:0] col_phase_r, col_phase_nxt;
  logic [PH_W-1:0] row_phase_r, row_phase_nxt;
  logic [AW-1:0]   blk_col_r, blk_col_nxt;

  logic [SW_W-1:0] cp_inc, rp_inc;
  logic [WD_W-1:0] sc_inc;
  logic [HD_W-1:0] sr_inc;
  logic [XW-1:0]   col_base, row_base;
  logic            col_fit, row_fit, col_end, row_end;
  logic            in_block, blk_first, blk_last;
  logic            in_ready, in_fire;

  // band memory and write-back stage
  logic [3*SUM_W-1:0] band_mem [MAX_WIDTH];
  logic [3*SUM_W-1:0] rd_r;
  logic               p_valid_r, p_first_r, p_last_r, p_fend_r;
  logic [AW-1:0]      p_addr_r;
  logic [PIX_W-1:0]   p_px_r [3];
  logic               wb_valid_r;
  logic [AW-1:0]      wb_addr_r;
  logic [3*SUM_W-1:0] wb_data_r;
  logic               fwd_hit;
  logic [SUM_W-1:0]   base [3];
  logic [SUM_W-1:0]   sum [3];
  logic [3*SUM_W-1:0] sum_word;

  // divider
  bxds_pkg::div_state_t div_state_r, div_state_nxt;
  logic [CNT_W-1:0] count;
  logic [DW-1:0]    div_rem_r [3];
  logic [QUO_W-1:0] div_q_r [3];
  logic [KW-1:0]    div_k_r;
  logic             div_fend_r;
  logic [DW-1:0]    div_sub;
  logic [DW:0]      div_bound;
  logic             div_rem_ok;
  logic             div_start, div_step, out_load, out_free;

  // output register
  logic             out_valid_r;
  logic [PIX_W-1:0] out_avg_r [3];
  logic             out_fend_r;

  // ---------------------------------------------------------------- config
  assign cfg_s5 = cfg_data[bxds_pkg::STRIDE_CFG_W-1:0];

  always_comb begin
    if (cfg_data == '0) begin
      w_cl = WD_W'(1);
      h_cl = HD_W'(1);
    end else begin
      w_cl = (cfg_data > WMAX)  ? WD_W'(WMAX)  : WD_W'(cfg_data);
      h_cl = (cfg_data > MAX_H) ? HD_W'(MAX_H) : HD_W'(cfg_data);
    end
    if (cfg_s5 == '0) begin
      s_cl = SW_W'(1);
    end else if (cfg_s5 > MAX_STRIDE) begin
      s_cl = SW_W'(MAX_STRIDE);
    end else begin
      s_cl = SW_W'(cfg_s5);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r  <= WD_W'(1);
      h_r  <= HD_W'(1);
      sw_r <= SW_W'(1);
      sh_r <= SW_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        bxds_pkg::REG_IMAGE_WIDTH:   w_r  <= w_cl;
        bxds_pkg::REG_IMAGE_HEIGHT:  h_r  <= h_cl;
        bxds_pkg::REG_STRIDE_WIDTH:  sw_r <= s_cl;
        bxds_pkg::REG_STRIDE_HEIGHT: sh_r <= s_cl;
      endcase
    end
  end

  assign count = CNT_W'(CNT_W'(sw_r) * CNT_W'(sh_r));

  // ---------------------------------------------------------------- position
  assign col_base = XW'(src_col_r) - XW'(col_phase_r);
  assign row_base = XW'(src_row_r) - XW'(row_phase_r);
  assign col_fit  = (col_base + XW'(sw_r)) <= XW'(w_r);
  assign row_fit  = (row_base + XW'(sh_r)) <= XW'(h_r);
  assign col_end  = (col_base + XW'(sw_r) + XW'(sw_r)) > XW'(w_r);
  assign row_end  = (row_base + XW'(sh_r) + XW'(sh_r)) > XW'(h_r);

  assign cp_inc = SW_W'(col_phase_r) + SW_W'(1);
  assign rp_inc = SW_W'(row_phase_r) + SW_W'(1);
  assign sc_inc = WD_W'(src_col_r) + WD_W'(1);
  assign sr_inc = HD_W'(src_row_r) + HD_W'(1);

  assign in_block  = col_fit && row_fit;
  assign blk_first = (col_phase_r == '0) && (row_phase_r == '0);
  assign blk_last  = (cp_inc == sw_r) && (rp_inc == sh_r);

  assign in_ready = (div_state_r == bxds_pkg::DIV_IDLE) && !(p_valid_r && p_last_r);
  assign in_fire  = in_pix.valid && in_ready;
  assign in_pix.ready = in_ready;

  always_comb begin
    col_phase_nxt = PH_W'(cp_inc);
    blk_col_nxt   = blk_col_r;
    src_col_nxt   = SC_W'(sc_inc);
    row_phase_nxt = row_phase_r;
    src_row_nxt   = src_row_r;
    if (cp_inc >= sw_r) begin
      col_phase_nxt = '0;
      blk_col_nxt   = blk_col_r + AW'(1);
    end
    if (sc_inc >= w_r) begin
      src_col_nxt   = '0;
      col_phase_nxt = '0;
      blk_col_nxt   = '0;
      row_phase_nxt = (rp_inc >= sh_r) ? '0 : PH_W'(rp_inc);
      src_row_nxt   = SR_W'(sr_inc);
      if (sr_inc >= h_r) begin
        src_row_nxt   = '0;
        row_phase_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) begin
      src_col_r   <= '0;
      src_row_r   <= '0;
      col_phase_r <= '0;
      row_phase_r <= '0;
      blk_col_r   <= '0;
    end else if (in_fire) begin
      src_col_r   <= src_col_nxt;
      src_row_r   <= src_row_nxt;
      col_phase_r <= col_phase_nxt;
      row_phase_r <= row_phase_nxt;
      blk_col_r   <= blk_col_nxt;
    end
  end

  // ---------------------------------------------------------------- band memory
  always_ff @(posedge clk) begin
    if (p_valid_r) begin
      band_mem[p_addr_r] <= sum_word;
    end
    if (in_fire) begin
      rd_r <= band_mem[blk_col_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r  <= 1'b0;
      wb_valid_r <= 1'b0;
    end else begin
      p_valid_r  <= in_fire && in_block;
      wb_valid_r <= p_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      p_addr_r  <= blk_col_r;
      p_first_r <= blk_first;
      p_last_r  <= blk_last;
      p_fend_r  <= col_end && row_end;
      p_px_r[0] <= in_pix.red;
      p_px_r[1] <= in_pix.green;
      p_px_r[2] <= in_pix.blue;
    end
    wb_addr_r <= p_addr_r;
    wb_data_r <= sum_word;
  end

  // the previous write lands on the edge this item's read was taken
  assign fwd_hit = wb_valid_r && (wb_addr_r == p_addr_r);

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (p_first_r) begin
        base[c] = '0;
      end else if (fwd_hit) begin
        base[c] = wb_data_r[c*SUM_W +: SUM_W];
      end else begin
        base[c] = rd_r[c*SUM_W +: SUM_W];
      end
      sum[c] = base[c] + SUM_W'(p_px_r[c]);
    end
    sum_word = {sum[2], sum[1], sum[0]};
  end

  // ---------------------------------------------------------------- divider
  assign out_free = !out_valid_r || out_pix.ready;
  assign div_sub  = DW'(count) << div_k_r;

  always_comb begin
    div_state_nxt = div_state_r;
    unique case (div_state_r)
      bxds_pkg::DIV_IDLE: if (p_valid_r && p_last_r) div_state_nxt = bxds_pkg::DIV_RUN;
      bxds_pkg::DIV_RUN:  if (div_k_r == '0) div_state_nxt = bxds_pkg::DIV_DONE;
      bxds_pkg::DIV_DONE: if (out_free) div_state_nxt = bxds_pkg::DIV_IDLE;
      default:            div_state_nxt = bxds_pkg::DIV_IDLE;
    endcase
  end

  always_comb begin
    div_start = 1'b0;
    div_step  = 1'b0;
    out_load  = 1'b0;
    unique case (div_state_r)
      bxds_pkg::DIV_IDLE: div_start = p_valid_r && p_last_r;
      bxds_pkg::DIV_RUN:  div_step  = 1'b1;
      bxds_pkg::DIV_DONE: out_load  = out_free;
      default:            div_start = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_state_r <= bxds_pkg::DIV_IDLE;
    end else begin
      div_state_r <= div_state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (div_start) begin
      for (int c = 0; c < 3; c++) begin
        div_rem_r[c] <= DW'(sum[c]);
        div_q_r[c]   <= '0;
      end
      div_k_r    <= KW'(QUO_W - 1);
      div_fend_r <= p_fend_r;
    end else if (div_step) begin
      for (int c = 0; c < 3; c++) begin
        if (div_rem_r[c] >= div_sub) begin
          div_rem_r[c] <= div_rem_r[c] - div_sub;
          div_q_r[c]   <= {div_q_r[c][QUO_W-2:0], 1'b1};
        end else begin
          div_q_r[c]   <= {div_q_r[c][QUO_W-2:0], 1'b0};
        end
      end
      div_k_r <= div_k_r - KW'(1);
    end
  end

  // ---------------------------------------------------------------- output
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_pix.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      for (int c = 0; c < 3; c++) begin
        out_avg_r[c] <= PIX_W'(div_q_r[c]);
      end
      out_fend_r <= div_fend_r;
    end
  end

  assign out_pix.valid         = out_valid_r;
  assign out_pix.red_average   = out_avg_r[0];
  assign out_pix.green_average = out_avg_r[1];
  assign out_pix.blue_average  = out_avg_r[2];
  assign out_pix.frame_end     = out_fend_r;

  // ---------------------------------------------------------------- checks
  assign div_bound  = (DW + 1)'(count) << ((KW + 1)'(div_k_r) + (KW + 1)'(1));
  assign div_rem_ok = ((DW + 1)'(div_rem_r[0]) < div_bound) &&
                      ((DW + 1)'(div_rem_r[1]) < div_bound) &&
                      ((DW + 1)'(div_rem_r[2]) < div_bound);

  `ASSERT_IMPLIES(a_div_free_on_close, p_valid_r && p_last_r, div_state_r == bxds_pkg::DIV_IDLE)
  `ASSERT_IMPLIES(a_div_rem_bound, div_state_r == bxds_pkg::DIV_RUN, div_rem_ok)
  `ASSERT_ALWAYS(a_phase_in_stride, (col_phase_r < sw_r) && (row_phase_r < sh_r))

endmodule

/* bench/box_average_checker.sv */
module box_average_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  bxds_in_if                             in_pix,
  bxds_out_if                            out_pix,
  input  logic                           cfg_we,
  input  logic [bxds_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bxds_pkg::CFG_W-1:0]     cfg_data,
  output int                             fail_count,
  output int                             pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CFG_IDX_W    = bxds_pkg::CFG_IDX_W;
  localparam int CFG_W        = bxds_pkg::CFG_W;
  localparam int PIX_W        = bxds_pkg::PIX_W;
  localparam int QUO_W        = bxds_pkg::QUO_W;
  localparam int STRIDE_CFG_W = bxds_pkg::STRIDE_CFG_W;
  localparam int unsigned MAX_HEIGHT = bxds_pkg::MAX_HEIGHT;
  localparam int unsigned WIDTH_CAP  = bxds_pkg::DEF_MAX_WIDTH;
  localparam int unsigned STRIDE_CAP = bxds_pkg::DEF_MAX_STRIDE;

  typedef struct packed {
    logic [QUO_W-1:0] red;
    logic [QUO_W-1:0] green;
    logic [QUO_W-1:0] blue;
    logic             frame_end;
  } block_avg_t;

  block_avg_t  avg_queue[$];

  logic [CFG_W-1:0]        width_reg;
  logic [CFG_W-1:0]        height_reg;
  logic [STRIDE_CFG_W-1:0] stride_w_reg;
  logic [STRIDE_CFG_W-1:0] stride_h_reg;

  int unsigned red_sum[0:WIDTH_CAP-1];
  int unsigned green_sum[0:WIDTH_CAP-1];
  int unsigned blue_sum[0:WIDTH_CAP-1];
  int unsigned src_col, src_row, col_phase, row_phase, blk_col;

  function automatic int unsigned clamp_to(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic report_error(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    fail_count++;
  endtask

  task automatic restart_frame();
    src_col   = 0;
    src_row   = 0;
    col_phase = 0;
    row_phase = 0;
    blk_col   = 0;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    case (idx)
      bxds_pkg::REG_IMAGE_WIDTH:   width_reg    = data;
      bxds_pkg::REG_IMAGE_HEIGHT:  height_reg   = data;
      bxds_pkg::REG_STRIDE_WIDTH:  stride_w_reg = data[STRIDE_CFG_W-1:0];
      bxds_pkg::REG_STRIDE_HEIGHT: stride_h_reg = data[STRIDE_CFG_W-1:0];
      default: ;
    endcase
    restart_frame();
  endtask

  task automatic accumulate_pixel(input logic [PIX_W-1:0] r, g, b);
    int unsigned w, h, sw, sh, ow, oh, area;
    block_avg_t  avg;
    w  = clamp_to(width_reg, WIDTH_CAP);
    h  = clamp_to(height_reg, MAX_HEIGHT);
    sw = clamp_to(stride_w_reg, STRIDE_CAP);
    sh = clamp_to(stride_h_reg, STRIDE_CAP);
    ow = w / sw;
    oh = h / sh;
    if (blk_col < ow && src_row < oh * sh) begin
      if (col_phase == 0 && row_phase == 0) begin
        red_sum[blk_col]   = r;
        green_sum[blk_col] = g;
        blue_sum[blk_col]  = b;
      end else begin
        red_sum[blk_col]   += r;
        green_sum[blk_col] += g;
        blue_sum[blk_col]  += b;
      end
      if (col_phase == sw - 1 && row_phase == sh - 1) begin
        area          = sw * sh;
        avg.red       = QUO_W'(red_sum[blk_col] / area);
        avg.green     = QUO_W'(green_sum[blk_col] / area);
        avg.blue      = QUO_W'(blue_sum[blk_col] / area);
        avg.frame_end = (blk_col == ow - 1) && (src_row == oh * sh - 1);
        avg_queue.push_back(avg);
      end
    end
    col_phase++;
    if (col_phase >= sw) begin
      col_phase = 0;
      blk_col++;
    end
    src_col++;
    if (src_col >= w) begin
      src_col   = 0;
      col_phase = 0;
      blk_col   = 0;
      row_phase++;
      if (row_phase >= sh) row_phase = 0;
      src_row++;
      if (src_row >= h) begin
        src_row   = 0;
        row_phase = 0;
      end
    end
  endtask

  task automatic check_result();
    block_avg_t want;
    if (avg_queue.size() == 0) begin
      report_error($sformatf("unexpected item: avg %0d/%0d/%0d frame_end %0b",
                             out_pix.red_average, out_pix.green_average,
                             out_pix.blue_average, out_pix.frame_end));
      return;
    end
    want = avg_queue.pop_front();
    if (out_pix.red_average !== want.red)
      report_error($sformatf("red_average %0d, expected %0d", out_pix.red_average, want.red));
    if (out_pix.green_average !== want.green)
      report_error($sformatf("green_average %0d, expected %0d",
                             out_pix.green_average, want.green));
    if (out_pix.blue_average !== want.blue)
      report_error($sformatf("blue_average %0d, expected %0d",
                             out_pix.blue_average, want.blue));
    if (out_pix.frame_end !== want.frame_end)
      report_error($sformatf("frame_end %0b, expected %0b", out_pix.frame_end, want.frame_end));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      width_reg    = 1;
      height_reg   = 1;
      stride_w_reg = 1;
      stride_h_reg = 1;
      restart_frame();
      avg_queue.delete();
    end else begin
      if (cfg_we)
        write_reg(cfg_index, cfg_data);
      if (in_pix.valid === 1'b1 && in_pix.ready === 1'b1)
        accumulate_pixel(in_pix.red, in_pix.green, in_pix.blue);
      if (out_pix.valid === 1'b1 && out_pix.ready === 1'b1)
        check_result();
    end
    pending_count = avg_queue.size();
  end

endmodule

/* bench/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CFG_IDX_W = bxds_pkg::CFG_IDX_W;
  localparam int CFG_W     = bxds_pkg::CFG_W;
  localparam int PIX_W     = bxds_pkg::PIX_W;

  localparam int unsigned QUIET_LIMIT = 1000;
  localparam int unsigned ITEM_TARGET = 1550;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  int                   fail_count;
  int                   pending_count;
  int unsigned          items_sent;
  int unsigned          quiet_cycles;
  bit                   in_burst;
  bit                   out_burst;

  bxds_in_if  pix_in_ch();
  bxds_out_if pix_out_ch();

  box_average_downscaler dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_pix    (pix_in_ch),
    .out_pix   (pix_out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  box_average_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_pix        (pix_in_ch),
    .out_pix       (pix_out_ch),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if ((pix_in_ch.valid && pix_in_ch.ready) || (pix_out_ch.valid && pix_out_ch.ready) ||
        cfg_we)
      quiet_cycles <= 0;
    else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else
      quiet_cycles <= quiet_cycles + 1;
  end

  // registers only change once every expected item is out and the block has settled
  task automatic configure(input logic [CFG_W-1:0] w, h, sw, sh);
    pix_in_ch.valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (16) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= bxds_pkg::REG_IMAGE_WIDTH;
    cfg_data  <= w;
    @(negedge clk);
    cfg_index <= bxds_pkg::REG_IMAGE_HEIGHT;
    cfg_data  <= h;
    @(negedge clk);
    cfg_index <= bxds_pkg::REG_STRIDE_WIDTH;
    cfg_data  <= sw;
    @(negedge clk);
    cfg_index <= bxds_pkg::REG_STRIDE_HEIGHT;
    cfg_data  <= sh;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic send_pixel(input logic [PIX_W-1:0] r, g, b);
    int unsigned gap;
    gap = in_burst ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      pix_in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pix_in_ch.valid <= 1'b1;
    pix_in_ch.red   <= r;
    pix_in_ch.green <= g;
    pix_in_ch.blue  <= b;
    do @(posedge clk); while (!pix_in_ch.ready);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic send_random_pixels(input int unsigned count);
    repeat (count) send_pixel(PIX_W'($urandom), PIX_W'($urandom), PIX_W'($urandom));
  endtask

  task automatic take_results();
    int unsigned gap;
    forever begin
      if ($urandom_range(0, 31) == 0) out_burst = !out_burst;
      gap = out_burst ? 0 : $urandom_range(0, 15);
      if (gap != 0) begin
        pix_out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      pix_out_ch.ready <= 1'b1;
      do @(posedge clk); while (!pix_out_ch.valid);
      @(negedge clk);
    end
  endtask

  // mostly strides that fit the frame, now and then zero or above the cap
  function automatic logic [CFG_W-1:0] pick_stride(input int unsigned span);
    int unsigned pick, s;
    pick = $urandom_range(0, 9);
    if (pick == 0) s = 0;
    else if (pick == 1) s = $urandom_range(17, 31);
    else if (pick <= 5) s = $urandom_range(1, (span < 4) ? span : 4);
    else s = $urandom_range(1, (span < 16) ? span : 16);
    return {8'($urandom), 5'(s)};
  endfunction

  task automatic random_phase();
    int unsigned w, h, area, count;
    w     = $urandom_range(1, 24);
    h     = $urandom_range(1, 16);
    area  = w * h;
    count = area * $urandom_range(1, 3);
    if ($urandom_range(0, 3) == 0) count += $urandom_range(1, area);
    if (count > 300) count = 300;
    if (count > ITEM_TARGET - items_sent) count = ITEM_TARGET - items_sent;
    configure(CFG_W'(w), CFG_W'(h), pick_stride(w), pick_stride(h));
    in_burst = ($urandom_range(0, 3) == 0);
    send_random_pixels(count);
  endtask

  initial begin
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = bxds_pkg::REG_IMAGE_WIDTH;
    cfg_data         = '0;
    pix_in_ch.valid  = 1'b0;
    pix_in_ch.red    = '0;
    pix_in_ch.green  = '0;
    pix_in_ch.blue   = '0;
    pix_out_ch.ready = 1'b0;
    items_sent       = 0;
    quiet_cycles     = 0;
    in_burst         = 1'b0;
    out_burst        = 1'b0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    fork
      take_results();
    join_none

    // 2x2 frame, unit strides: extremes, then wrap into the next frame
    configure(13'd2, 13'd2, 13'd1, 13'd1);
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'h55, 8'hAA, 8'h0F);
    send_pixel(8'hAA, 8'h55, 8'hF0);
    send_pixel(8'hFF, 8'h00, 8'h80);
    send_pixel(8'h01, 8'h02, 8'h03);

    // 2x2 blocks, last column dropped
    configure(13'd5, 13'd2, 13'd2, 13'd2);
    send_pixel(8'hFF, 8'h00, 8'hFF);
    send_pixel(8'hFF, 8'h00, 8'hFF);
    send_pixel(8'h01, 8'h02, 8'h03);
    send_pixel(8'h03, 8'h02, 8'h01);
    send_pixel(8'h09, 8'h09, 8'h09);
    send_pixel(8'hFF, 8'h00, 8'hFF);
    send_pixel(8'hFF, 8'h00, 8'hFE);
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'h00, 8'h01, 8'h00);
    send_pixel(8'h07, 8'h07, 8'h07);

    // stride wider than the frame: nothing comes out
    configure(13'd3, 13'd1, 13'h1FE4, 13'd1);
    send_random_pixels(3);

    // all registers zero act as one
    configure(13'd0, 13'd0, 13'd0, 13'd0);
    send_random_pixels(3);

    // oversized width, height and stride width clamp; stride height takes 1
    configure(13'h1FFF, 13'h1FFF, 13'h1FFF, 13'h1FE1);
    in_burst = 1'b1;
    send_random_pixels(200);

    while (items_sent < ITEM_TARGET) random_phase();

    pix_in_ch.valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0 && pending_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+src
src/bxds_pkg.sv
src/bxds_if.sv
src/box_average_downscaler.sv
bench/box_average_checker.sv
bench/tb.sv
